// ===== hdl/lrgf_pkg.sv =====
// Shared types and constants for the low-rate bin gap finder.
// No dependencies; every other file of the block but the store uses this package.
package lrgf_pkg;

	localparam int MAX_BINS_DEF   = 128;
	localparam int COUNT_BITS_DEF = 32;
	localparam int RESULT_CAP     = 64;
	localparam int FACTOR_W       = 10;
	localparam int FRAC_W         = 8;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 10'd179;

	typedef struct packed {
		logic [31:0] bin_count;
		logic        last_bin;
	} in_item_t;

	typedef struct packed {
		logic        has_interval;
		logic [6:0]  interval_start;
		logic [7:0]  interval_end;
		logic [31:0] mean_count;
		logic [32:0] threshold_count;
		logic        last_result;
	} out_item_t;

endpackage

// ===== hdl/low_rate_bin_gap_finder_core.sv =====
// Low-rate bin gap finder. Bins are accepted one per cycle while the job queue is
// empty and the back end idle. After the last bin come the job pop, a shift-subtract
// divide of the SUM_W (39) bit sum, the threshold, the scan of the bins loaded and a
// flush; an earlier result is loaded when the scan closes the run after it.
// New bins wait until the final result is valid; result stalls can hold scan and flush.
// Reset clears control state and sets the factor to 179; the store is not cleared.
module low_rate_bin_gap_finder_core #(
	parameter int MAX_BINS   = lrgf_pkg::MAX_BINS_DEF,
	parameter int COUNT_BITS = lrgf_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lrgf_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lrgf_pkg::out_item_t           out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lrgf_pkg::FACTOR_W-1:0] cfg_data
);
	import lrgf_pkg::*;

	localparam int ADDR_W = $clog2(MAX_BINS);
	localparam int IDX_W  = $clog2(MAX_BINS + 1);
	localparam int SUM_W  = COUNT_BITS + $clog2(MAX_BINS);

	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [COUNT_BITS-1:0] rd_data;
	logic                  push, q_full, pop, back_busy;
	logic [SUM_W-1:0]      f_sum, q_sum;
	logic [IDX_W-1:0]      f_n, q_n, f_loaded, q_loaded;

	lrgf_front #(
		.MAX_BINS(MAX_BINS), .COUNT_BITS(COUNT_BITS),
		.ADDR_W(ADDR_W), .IDX_W(IDX_W), .SUM_W(SUM_W)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.hold(q_full || back_busy),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.push(push), .job_sum(f_sum), .job_n(f_n), .job_loaded(f_loaded)
	);

	lrgf_job_q #(.IDX_W(IDX_W), .SUM_W(SUM_W)) u_job_q (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_sum(f_sum), .push_n(f_n), .push_loaded(f_loaded),
		.full(q_full), .pop(pop),
		.pop_sum(q_sum), .pop_n(q_n), .pop_loaded(q_loaded)
	);

	lrgf_store #(.DEPTH(MAX_BINS), .WIDTH(COUNT_BITS), .ADDR_W(ADDR_W)) u_store (
		.clk(clk),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	lrgf_back #(
		.MAX_BINS(MAX_BINS), .COUNT_BITS(COUNT_BITS),
		.ADDR_W(ADDR_W), .IDX_W(IDX_W), .SUM_W(SUM_W)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.job_valid(q_full), .job_pop(pop),
		.job_sum(q_sum), .job_n(q_n), .job_loaded(q_loaded),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.busy(back_busy),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

endmodule

// ===== hdl/lrgf_store.sv =====
// Count store: one write port, one registered read port.
// Depends on nothing; contents are undefined until written.
module lrgf_store #(
	parameter int DEPTH  = 128,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/lrgf_front.sv =====
// Front end: accepts bins, writes them to the store, keeps sum and counts.
// Depends on lrgf_pkg; pushes one job per series into the job queue.
module lrgf_front #(
	parameter int MAX_BINS   = lrgf_pkg::MAX_BINS_DEF,
	parameter int COUNT_BITS = lrgf_pkg::COUNT_BITS_DEF,
	parameter int ADDR_W     = $clog2(MAX_BINS),
	parameter int IDX_W      = $clog2(MAX_BINS + 1),
	parameter int SUM_W      = COUNT_BITS + $clog2(MAX_BINS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lrgf_pkg::in_item_t  in_item,
	input  logic                hold,
	output logic                wr_en,
	output logic [ADDR_W-1:0]   wr_addr,
	output logic [COUNT_BITS-1:0] wr_data,
	output logic                push,
	output logic [SUM_W-1:0]    job_sum,
	output logic [IDX_W-1:0]    job_n,
	output logic [IDX_W-1:0]    job_loaded
);
	import lrgf_pkg::*;

	logic [IDX_W-1:0] loaded_q;
	logic [IDX_W-1:0] nz_q;
	logic [SUM_W-1:0] sum_q;
	logic             accept;
	logic             room;
	logic             nonzero;
	logic [COUNT_BITS-1:0] count;

	assign in_ready = !hold;
	assign accept   = in_valid && in_ready;
	assign count    = COUNT_BITS'(in_item.bin_count);
	assign room     = loaded_q < IDX_W'(MAX_BINS);
	assign nonzero  = count != '0;

	assign wr_en   = accept && room;
	assign wr_addr = loaded_q[ADDR_W-1:0];
	assign wr_data = count;

	// next values of the series state, also what a last bin hands to the back end
	always_comb begin
		job_loaded = loaded_q;
		job_n      = nz_q;
		job_sum    = sum_q;
		if (room) begin
			job_loaded = loaded_q + 1'b1;
			if (nonzero) begin
				job_n   = nz_q + 1'b1;
				job_sum = sum_q + SUM_W'(count);
			end
		end
	end

	assign push = accept && in_item.last_bin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			nz_q     <= '0;
			sum_q    <= '0;
		end else if (accept) begin
			if (in_item.last_bin) begin
				loaded_q <= '0;
				nz_q     <= '0;
				sum_q    <= '0;
			end else begin
				loaded_q <= job_loaded;
				nz_q     <= job_n;
				sum_q    <= job_sum;
			end
		end
	end

endmodule

// ===== hdl/lrgf_job_q.sv =====
// Job queue between front and back end: one slot holding a finished series.
// Depends on lrgf_pkg for default widths only.
module lrgf_job_q #(
	parameter int IDX_W = $clog2(lrgf_pkg::MAX_BINS_DEF + 1),
	parameter int SUM_W = lrgf_pkg::COUNT_BITS_DEF + $clog2(lrgf_pkg::MAX_BINS_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [SUM_W-1:0] push_sum,
	input  logic [IDX_W-1:0] push_n,
	input  logic [IDX_W-1:0] push_loaded,
	output logic             full,
	input  logic             pop,
	output logic [SUM_W-1:0] pop_sum,
	output logic [IDX_W-1:0] pop_n,
	output logic [IDX_W-1:0] pop_loaded
);

	logic             full_q;
	logic [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] loaded_q;

	assign full       = full_q;
	assign pop_sum    = sum_q;
	assign pop_n      = n_q;
	assign pop_loaded = loaded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push) begin
			full_q <= 1'b1;
		end else if (pop) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			sum_q    <= push_sum;
			n_q      <= push_n;
			loaded_q <= push_loaded;
		end
	end

endmodule

// ===== hdl/lrgf_back.sv =====
// Back end: mean by shift-subtract divide, threshold, pipelined scan of the
// store and result output register. Depends on lrgf_pkg.
module lrgf_back #(
	parameter int MAX_BINS   = lrgf_pkg::MAX_BINS_DEF,
	parameter int COUNT_BITS = lrgf_pkg::COUNT_BITS_DEF,
	parameter int ADDR_W     = $clog2(MAX_BINS),
	parameter int IDX_W      = $clog2(MAX_BINS + 1),
	parameter int SUM_W      = COUNT_BITS + $clog2(MAX_BINS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lrgf_pkg::FACTOR_W-1:0] cfg_data,
	input  logic                         job_valid,
	output logic                         job_pop,
	input  logic [SUM_W-1:0]             job_sum,
	input  logic [IDX_W-1:0]             job_n,
	input  logic [IDX_W-1:0]             job_loaded,
	output logic                         rd_en,
	output logic [ADDR_W-1:0]            rd_addr,
	input  logic [COUNT_BITS-1:0]        rd_data,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output lrgf_pkg::out_item_t          out_item
);
	import lrgf_pkg::*;

	localparam int CMP_W  = SUM_W + FACTOR_W;
	localparam int PROD_W = COUNT_BITS + IDX_W;
	localparam int TPR_W  = COUNT_BITS + FACTOR_W;
	localparam int THR_W  = TPR_W - FRAC_W;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int RC_W   = $clog2(RESULT_CAP + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]          state_q;
	logic [FACTOR_W-1:0] factor_q;
	logic [IDX_W-1:0]    n_q;
	logic [IDX_W-1:0]    loaded_q;
	logic [SUM_W-1:0]    div_q;
	logic [IDX_W-1:0]    rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [CMP_W-1:0]    rhs_q;
	logic [COUNT_BITS-1:0] mean_q;
	logic [THR_W-1:0]    thr_q;

	logic [IDX_W-1:0]    ptr_q;
	logic                issue_done_q;
	logic                v_s1, sent_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                v_s2, sent_s2;
	logic [IDX_W-1:0]    idx_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic                in_run_q;
	logic [IDX_W-1:0]    run_start_q;
	logic                pend_v_q;
	logic [IDX_W-1:0]    pend_start_q;
	logic [IDX_W-1:0]    pend_end_q;
	logic [RC_W-1:0]     res_cnt_q;
	logic                out_v_q;
	out_item_t           out_q;

	logic [IDX_W:0]      rem_sh;
	logic [IDX_W:0]      rem_diff;
	logic                rem_ge;
	logic [COUNT_BITS-1:0] mean_nxt;
	logic [TPR_W-1:0]    thr_prod;
	logic [CMP_W-1:0]    lhs;
	logic                low, close_run, out_free, stall, adv, issue, sent_issue;
	logic                cap_hit, scan_done;
	logic                out_load;

	assign cfg_ready = 1'b1;
	assign busy      = state_q != ST_IDLE;
	assign job_pop   = (state_q == ST_IDLE) && job_valid;
	assign out_valid = out_v_q;
	assign out_item  = out_q;

	// one quotient bit per cycle
	assign rem_sh   = {rem_q, div_q[SUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, n_q};
	assign rem_ge   = rem_sh >= {1'b0, n_q};

	assign mean_nxt = (n_q == '0) ? '0 : div_q[COUNT_BITS-1:0];
	assign thr_prod = TPR_W'(mean_nxt) * TPR_W'(factor_q);

	// a bin is low when count * n * 256 < sum * factor
	assign lhs       = CMP_W'({prod_s2, {FRAC_W{1'b0}}});
	assign low       = v_s2 && !sent_s2 && (lhs < rhs_q);
	assign close_run = v_s2 && in_run_q && !low;
	assign out_free  = !out_v_q || out_ready;
	assign stall     = close_run && pend_v_q && !out_free;
	assign adv       = (state_q == ST_SCAN) && !stall;
	assign issue     = adv && !issue_done_q;
	assign sent_issue = ptr_q == loaded_q;
	assign cap_hit   = close_run && (res_cnt_q == RC_W'(RESULT_CAP - 1));
	assign scan_done = adv && v_s2 && (sent_s2 || cap_hit);

	// the previous run is now known not to be the final one, or the flush loads the final result
	assign out_load = ((state_q == ST_SCAN) && adv && close_run && pend_v_q) ||
	                  ((state_q == ST_FLUSH) && out_free);

	assign rd_en   = issue && !sent_issue;
	assign rd_addr = ptr_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			factor_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			issue_done_q <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			in_run_q     <= 1'b0;
			pend_v_q     <= 1'b0;
			res_cnt_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					issue_done_q <= 1'b0;
					v_s1         <= 1'b0;
					v_s2         <= 1'b0;
					in_run_q     <= 1'b0;
					pend_v_q     <= 1'b0;
					res_cnt_q    <= '0;
					state_q      <= ST_SCAN;
				end
				ST_SCAN: begin
					if (adv) begin
						if (issue && sent_issue) begin
							issue_done_q <= 1'b1;
						end
						v_s1 <= issue;
						v_s2 <= v_s1;
						if (low && !in_run_q) begin
							in_run_q <= 1'b1;
						end
						if (close_run) begin
							in_run_q  <= 1'b0;
							pend_v_q  <= 1'b1;
							res_cnt_q <= res_cnt_q + 1'b1;
						end
						if (scan_done) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				div_q    <= job_sum;
				rem_q    <= '0;
				n_q      <= job_n;
				loaded_q <= job_loaded;
				rhs_q    <= CMP_W'(job_sum) * CMP_W'(factor_q);
			end
			ST_DIV: begin
				rem_q <= rem_ge ? rem_diff[IDX_W-1:0] : rem_sh[IDX_W-1:0];
				div_q <= {div_q[SUM_W-2:0], rem_ge};
			end
			ST_MUL: begin
				mean_q <= mean_nxt;
				thr_q  <= thr_prod[TPR_W-1:FRAC_W];
				ptr_q  <= '0;
			end
			ST_SCAN: begin
				if (adv) begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
					idx_s1  <= ptr_q;
					sent_s1 <= sent_issue;
					idx_s2  <= idx_s1;
					sent_s2 <= sent_s1;
					prod_s2 <= PROD_W'(rd_data) * PROD_W'(n_q);
					if (low && !in_run_q) begin
						run_start_q <= idx_s2;
					end
					if (close_run) begin
						pend_start_q <= run_start_q;
						pend_end_q   <= idx_s2;
						if (pend_v_q) begin
							out_q.has_interval    <= 1'b1;
							out_q.interval_start  <= 7'(pend_start_q);
							out_q.interval_end    <= 8'(pend_end_q);
							out_q.mean_count      <= 32'(mean_q);
							out_q.threshold_count <= 33'(thr_q);
							out_q.last_result     <= 1'b0;
						end
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_q.has_interval    <= pend_v_q;
					out_q.interval_start  <= pend_v_q ? 7'(pend_start_q) : '0;
					out_q.interval_end    <= pend_v_q ? 8'(pend_end_q) : '0;
					out_q.mean_count      <= 32'(mean_q);
					out_q.threshold_count <= 33'(thr_q);
					out_q.last_result     <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/lrgf_checker.sv =====
// Port-level checks for the gap finder, bound to the top level.
// Depends on lrgf_pkg and low_rate_bin_gap_finder_core.
module lrgf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input lrgf_pkg::out_item_t out_item
);
	import lrgf_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// an empty result always closes its series
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.has_interval |-> out_item.last_result)
		else $error("empty result not marked last");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.has_interval |->
			(out_item.interval_end > {1'b0, out_item.interval_start}))
		else $error("interval end not past start");

	// bins of a new series wait while a series still has results to come
	a_no_load_mid_scan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last_result |-> !in_ready)
		else $error("input taken while scan results pending");

endmodule

bind low_rate_bin_gap_finder_core lrgf_checker u_lrgf_checker (.*);
